// ----- rtl/swmm_pkg.sv -----
// Package for the sliding window min/max block: sample widths, register reset
// and the token that travels along the chain of cells.
// No dependencies.
package swmm_pkg;

    localparam int SAMPLE_W           = 32;
    localparam int PERIOD_W           = 6;
    localparam int DEFAULT_MAX_WINDOW = 64;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 6'd10;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] lo;
    } token_t;

endpackage

// ----- rtl/swmm_cell.sv -----
// One cell of the window chain: holds one sample and folds it into the
// passing min/max token when its place lies inside the window.
// Depends on swmm_pkg.
module swmm_cell
    import swmm_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int SPAN_W = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  logic [SAMPLE_W-1:0] sample_in,
    input  logic [SPAN_W-1:0]   span,
    input  token_t              token_in,
    output logic [SAMPLE_W-1:0] sample_out,
    output token_t              token_out
);

    logic [SAMPLE_W-1:0] sample_reg;
    logic                valid_reg;
    logic [SAMPLE_W-1:0] hi_reg;
    logic [SAMPLE_W-1:0] lo_reg;
    token_t              token_next;
    logic                fold_en;

    assign fold_en = token_in.valid && (IDX <= int'(span));

    always_comb
    begin
        token_next = token_in;
        if (fold_en)
        begin
            if ($signed(sample_reg) > $signed(token_in.hi))
            begin
                token_next.hi = sample_reg;
            end
            if ($signed(sample_reg) < $signed(token_in.lo))
            begin
                token_next.lo = sample_reg;
            end
        end
    end

    // advance the sample only on an accepted request
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            sample_reg <= sample_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= token_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= token_next.hi;
        lo_reg <= token_next.lo;
    end

    assign sample_out = sample_reg;
    assign token_out  = '{valid: valid_reg, hi: hi_reg, lo: lo_reg};

endmodule

// ----- rtl/sliding_window_min_max_top.sv -----
// Top level of the sliding window min/max block: control, fill count and the
// chain of swmm_cell instances. Depends on swmm_pkg and swmm_cell.
//
// Samples shift into a row of MAX_WINDOW cells, newest first, one place per
// accepted request. A request that yields a result launches a token that walks
// the row one cell per cycle, each cell inside the window folding its sample
// in. No new request is taken until the token has left the row; the next one
// can then be taken while the result is shown, if the result register is free
// or m_axis_tready is high. A request that yields no result does not make the
// block busy. The window length is clamped to MAX_WINDOW samples; write
// window_period only while idle.
module sliding_window_min_max_top
    import swmm_pkg::*;
#(
    parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [PERIOD_W-1:0]   cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,  // sample_value
    input  logic                  s_axis_tuser,  // series_start
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [2*SAMPLE_W-1:0] m_axis_tdata   // window_min, window_max
);

    localparam int SPAN_W = $clog2(MAX_WINDOW);
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);

    logic [PERIOD_W-1:0] period_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic [SPAN_W-1:0]   span_reg;
    logic [SPAN_W-1:0]   span_next;
    logic                busy_reg;
    logic                in_acc;
    logic                out_acc;
    logic                produce;
    logic                inject_valid_reg;
    logic [SAMPLE_W-1:0] inject_hi_reg;
    logic [SAMPLE_W-1:0] inject_lo_reg;
    token_t              inject_token;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_hi_reg;
    logic [SAMPLE_W-1:0] out_lo_reg;
    logic [SAMPLE_W-1:0] cell_sample [MAX_WINDOW];
    token_t              cell_token  [MAX_WINDOW];

    assign s_axis_tready = !busy_reg && (!out_valid_reg || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign inject_token  = '{valid: inject_valid_reg, hi: inject_hi_reg, lo: inject_lo_reg};

    always_comb
    begin
        if (32'(period_reg) > MAX_WINDOW - 1)
        begin
            span_next = SPAN_W'(MAX_WINDOW - 1);
        end
        else
        begin
            span_next = SPAN_W'(period_reg);
        end
        if (s_axis_tuser)
        begin
            fill_next = FILL_W'(1);
        end
        else if (32'(fill_reg) < MAX_WINDOW)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end
        produce = 32'(fill_next) >= 32'(span_next) + 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg       <= PERIOD_RESET;
            fill_reg         <= '0;
            busy_reg         <= 1'b0;
            inject_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            if (in_acc)
            begin
                fill_reg <= fill_next;
            end
            inject_valid_reg <= in_acc && produce;
            if (in_acc && produce)
            begin
                busy_reg <= 1'b1;
            end
            else if (cell_token[MAX_WINDOW-1].valid)
            begin
                busy_reg <= 1'b0;
            end
            if (cell_token[MAX_WINDOW-1].valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            span_reg      <= span_next;
            inject_hi_reg <= s_axis_tdata;
            inject_lo_reg <= s_axis_tdata;
        end
        if (cell_token[MAX_WINDOW-1].valid)
        begin
            out_hi_reg <= cell_token[MAX_WINDOW-1].hi;
            out_lo_reg <= cell_token[MAX_WINDOW-1].lo;
        end
    end

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            swmm_cell #(
                .IDX    (i),
                .SPAN_W (SPAN_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (in_acc),
                .sample_in  (s_axis_tdata),
                .span       (span_reg),
                .token_in   (inject_token),
                .sample_out (cell_sample[i]),
                .token_out  (cell_token[i])
            );
        end
        else
        begin : g_body
            swmm_cell #(
                .IDX    (i),
                .SPAN_W (SPAN_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (in_acc),
                .sample_in  (cell_sample[i-1]),
                .span       (span_reg),
                .token_in   (cell_token[i-1]),
                .sample_out (cell_sample[i]),
                .token_out  (cell_token[i])
            );
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_lo_reg, out_hi_reg};

endmodule

// ----- rtl/swmm_checker.sv -----
// Port-level checker for the sliding window min/max block, bound to the top.
// Depends on swmm_pkg and sliding_window_min_max_top.
module swmm_checker
    import swmm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [2*SAMPLE_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while result stalled");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result too soon after request");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[SAMPLE_W-1:0]) >= $signed(m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]))
        else $error("window maximum below minimum");

    a_reset: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

endmodule

bind sliding_window_min_max_top swmm_checker u_swmm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
